// ===== hw/rtl/pedq_pkg.sv =====
`timescale 1ns / 1ps

package pedq_pkg;

  // Field widths.
  localparam int unsigned SampleW = 12;
  localparam int unsigned SpanW   = 16;
  localparam int unsigned LevelW  = 9;
  localparam int unsigned SettleW = 10;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned NumW    = 28;

  // Full-scale ADC count used by the linear map.
  localparam logic [SampleW-1:0] FullScale = 12'd4095;

  // Half of the map divisor 128 * 4095, added before the divide to round.
  localparam logic [NumW-1:0] HalfDenom = 28'd262080;

  // Remainder bound of the divide by 4095.
  localparam logic [21:0] DivConst = 22'd4095;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_SPAN_LOW  = 3'd0,
    CFG_SPAN_HIGH = 3'd1,
    CFG_REVERSE   = 3'd2,
    CFG_DEADBAND  = 3'd3,
    CFG_SETTLE    = 3'd4
  } cfg_idx_e;

  // Reset values of the configuration registers.
  localparam logic [SpanW-1:0]   SpanLowRst  = 16'h8100;
  localparam logic [SpanW-1:0]   SpanHighRst = 16'h0000;
  localparam logic [SampleW-1:0] DeadbandRst = 12'd12;
  localparam logic [SettleW-1:0] SettleRst   = 10'd50;

endpackage

// ===== hw/rtl/pot_ema_deadband_quantizer.sv =====
`timescale 1ns / 1ps

// Potentiometer smoothing filter with deadband and half-dB level quantizer.
//
// The slave channel takes one ADC sample per item; tuser flags a start item,
// which seeds the filter and arms the settle countdown. Every other item
// runs the moving average (filtered += (sample - filtered) / 8). The master
// channel carries a new level in half-dB units, with tuser set when it is the
// boot sync issued at the end of the settle countdown. After that, a level is
// sent only once the filter has left the deadband around the last sent value
// and the mapped level changed.
//
// Throughput is one item per cycle while s_axis_tready is high. A result
// reaches the output register through the filter update, registered at the
// edge that accepts its item, then the span multiply, the rounding divide by
// 128 * 4095 and the send decision, which each add a stage. Reset clears the
// filter and all pipeline valid bits and loads the register reset values. When
// the receiver stalls, the output register holds its result and the stages
// behind it fill up; s_axis_tready falls only when every stage holds an item.
// The user must write configuration while idle; the block does not enforce it.
module pot_ema_deadband_quantizer
  import pedq_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // Configuration write port.
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_addr_i,
  input  logic [SpanW-1:0]    cfg_wdata_i,
  // Sample channel.
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [15:0]         s_axis_tdata,   // [11:0] sample
  input  logic                s_axis_tuser,   // [0] start_req
  // Level channel.
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [15:0]         m_axis_tdata,   // [8:0] level_half_db
  output logic                m_axis_tuser    // [0] boot_sync
);

  // Configuration registers.
  logic [SpanW-1:0]   span_low_q, span_high_q;
  logic               reverse_q;
  logic [SampleW-1:0] deadband_q;
  logic [SettleW-1:0] settle_ticks_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      span_low_q     <= SpanLowRst;
      span_high_q    <= SpanHighRst;
      reverse_q      <= 1'b0;
      deadband_q     <= DeadbandRst;
      settle_ticks_q <= SettleRst;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        CFG_SPAN_LOW:  span_low_q     <= cfg_wdata_i;
        CFG_SPAN_HIGH: span_high_q    <= cfg_wdata_i;
        CFG_REVERSE:   reverse_q      <= cfg_wdata_i[0];
        CFG_DEADBAND:  deadband_q     <= cfg_wdata_i[SampleW-1:0];
        CFG_SETTLE:    settle_ticks_q <= cfg_wdata_i[SettleW-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline control.
  logic v1_q, v2_q, v3_q, out_valid_q;
  logic en1, en2, en3, can_out, emit3, take3, accept, pass1;

  // ---------------------------------------------------------------------------
  // Stage 1: filter and settle countdown.
  logic [SampleW-1:0] sample;
  logic               start_req;
  logic [SampleW-1:0] filt_q, filt_d, filt_new;
  logic [SettleW-1:0] settle_q, settle_d, settle_dec;
  logic signed [12:0] diff, diff_adj, filt_sum;
  logic signed [9:0]  ema_step;
  logic               boot1_d;
  logic [SampleW-1:0] filt1_q;
  logic               boot1_q;

  assign sample    = s_axis_tdata[SampleW-1:0];
  assign start_req = s_axis_tuser;
  assign accept    = s_axis_tvalid && s_axis_tready;

  // The shift of a negative difference is biased so it truncates toward zero.
  always_comb begin
    diff       = $signed({1'b0, sample}) - $signed({1'b0, filt_q});
    diff_adj   = diff + (diff[12] ? 13'sd7 : 13'sd0);
    ema_step   = diff_adj[12:3];
    filt_sum   = $signed({1'b0, filt_q}) + {{3{ema_step[9]}}, ema_step};
    filt_new   = filt_sum[SampleW-1:0];
    settle_dec = settle_q - 10'd1;

    filt_d   = filt_q;
    settle_d = settle_q;
    pass1    = 1'b0;
    boot1_d  = 1'b0;
    if (accept) begin
      if (start_req) begin
        filt_d   = sample;
        settle_d = settle_ticks_q;
      end else begin
        filt_d = filt_new;
        if (settle_q != '0) begin
          settle_d = settle_dec;
          pass1    = (settle_dec == '0);
          boot1_d  = 1'b1;
        end else begin
          pass1 = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filt_q   <= '0;
      settle_q <= '0;
    end else begin
      filt_q   <= filt_d;
      settle_q <= settle_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      filt1_q <= filt_new;
      boot1_q <= boot1_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: numerator low * (4095 - p) + high * p as low * 4095 + span * p.
  logic [SampleW-1:0]   p_val;
  logic signed [16:0]   span_diff;
  logic signed [29:0]   prod, low_x, num_full;
  logic signed [NumW-1:0] num2_q;
  logic [SampleW-1:0]   filt2_q;
  logic                 boot2_q;

  always_comb begin
    p_val     = reverse_q ? (FullScale - filt1_q) : filt1_q;
    span_diff = $signed({span_high_q[SpanW-1], span_high_q})
              - $signed({span_low_q[SpanW-1], span_low_q});
    prod      = span_diff * $signed({1'b0, p_val});
    low_x     = $signed({{2{span_low_q[SpanW-1]}}, span_low_q, 12'b0})
              - $signed({{14{span_low_q[SpanW-1]}}, span_low_q});
    num_full  = low_x + prod;
  end

  always_ff @(posedge clk_i) begin
    if (en2) begin
      num2_q  <= num_full[NumW-1:0];
      filt2_q <= filt1_q;
      boot2_q <= boot1_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: round half away from zero, divide by 128 then by 4095.
  // The quotient estimate y * 4097 / 2^24 is low by at most one.
  logic [NumW-1:0]      num_neg;
  logic [26:0]          mag;
  logic [NumW-1:0]      x_val;
  logic [20:0]          y_val;
  logic [32:0]          t_val;
  logic [8:0]           q0;
  logic [21:0]          rem;
  logic [9:0]           q_val, q_neg;
  logic signed [LevelW-1:0] level_d, level3_q;
  logic [SampleW-1:0]   filt3_q;
  logic                 boot3_q;

  always_comb begin
    num_neg = '0 - num2_q;
    mag     = num2_q[NumW-1] ? num_neg[26:0] : num2_q[26:0];
    x_val   = {1'b0, mag} + HalfDenom;
    y_val   = x_val[NumW-1:7];
    t_val   = {y_val, 12'b0} + {12'b0, y_val};
    q0      = t_val[32:24];
    rem     = {1'b0, y_val} - {1'b0, q0, 12'b0} + {13'b0, q0};
    q_val   = {1'b0, q0} + {9'b0, (rem >= DivConst)};
    q_neg   = 10'd0 - q_val;
    if (num2_q[NumW-1]) begin
      level_d = q_neg[LevelW-1:0];
    end else if (q_val > 10'd255) begin
      level_d = 9'sd255;
    end else begin
      level_d = q_val[LevelW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en3) begin
      level3_q <= level_d;
      filt3_q  <= filt2_q;
      boot3_q  <= boot2_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: deadband and change check against the last sent values.
  logic [SampleW-1:0]       sent_raw_q;
  logic signed [LevelW-1:0] sent_half_db_q;
  logic signed [12:0]       moved_s, moved_n;
  logic [SampleW-1:0]       moved;
  logic signed [LevelW-1:0] out_level_q;
  logic                     out_boot_q;

  always_comb begin
    moved_s = $signed({1'b0, filt3_q}) - $signed({1'b0, sent_raw_q});
    moved_n = 13'sd0 - moved_s;
    moved   = moved_s[12] ? moved_n[SampleW-1:0] : moved_s[SampleW-1:0];
    emit3   = boot3_q || ((moved > deadband_q) && (level3_q != sent_half_db_q));
    can_out = !out_valid_q || m_axis_tready;
    take3   = v3_q && (!emit3 || can_out);
    en3     = !v3_q || take3;
    en2     = !v2_q || en3;
    en1     = !v1_q || en2;
  end

  assign s_axis_tready = en1;

  // Valid bits and the last sent values.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q           <= 1'b0;
      v2_q           <= 1'b0;
      v3_q           <= 1'b0;
      out_valid_q    <= 1'b0;
      sent_raw_q     <= '0;
      sent_half_db_q <= '0;
    end else begin
      if (en1) v1_q <= pass1;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (take3 && emit3) begin
        out_valid_q    <= 1'b1;
        sent_raw_q     <= filt3_q;
        sent_half_db_q <= level3_q;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Output payload.
  always_ff @(posedge clk_i) begin
    if (take3 && emit3) begin
      out_level_q <= level3_q;
      out_boot_q  <= boot3_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'b0, out_level_q};
  assign m_axis_tuser  = out_boot_q;

  // ---------------------------------------------------------------------------
  // Assertions.

  // The input side only backs up once every stage holds an item.
  a_ready_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (v1_q && v2_q && v3_q && out_valid_q))
    else $error("input stalled with a free pipeline stage");

  // An item blocked in the last stage stays there unchanged.
  a_stage3_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v3_q && !en3) |=> (v3_q && $stable(level3_q) && $stable(filt3_q)))
    else $error("blocked item in the decision stage was lost");

  // A movement result always carries a level that differs from the last one.
  a_track_new: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take3 && emit3 && !boot3_q) |-> (level3_q != sent_half_db_q))
    else $error("movement result repeats the last sent level");

  // Each sent result updates the reference for the deadband check.
  a_sent_raw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take3 && emit3) |=> (sent_raw_q == $past(filt3_q) && out_valid_q))
    else $error("sent raw value not updated on a result");

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import pedq_pkg::*;

  localparam int  IdlePct     = 13;
  localparam int  HoldCycles  = 300;
  localparam int  DrainCycles = 8;
  localparam int  CycleLimit  = 200000;
  localparam int  NumPhases   = 10;
  localparam int  CalmPhase   = 4;
  localparam int  LongPhase   = 3;
  localparam int  EmaDiv      = 8;
  localparam longint MapDenom = 128 * 4095;
  localparam logic [CfgIdxW-1:0] CfgIdxSpare = CfgIdxW'(int'(CFG_SETTLE) + 1);

  typedef struct packed {
    logic signed [LevelW-1:0] level;
    logic                     boot;
  } level_t;

  typedef struct packed {
    logic   valid;
    level_t lvl;
  } step_out_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;
  typedef enum logic [1:0] {CHK_PRED, CHK_NONE, CHK_LEVEL} row_chk_e;

  typedef struct packed {
    row_kind_e                kind;
    logic [CfgIdxW-1:0]       idx;
    logic [SpanW-1:0]         value;
    logic [SampleW-1:0]       smp;
    logic                     st;
    row_chk_e                 chk;
    logic signed [LevelW-1:0] exp_level;
    logic                     exp_boot;
  } dir_row_t;

  localparam int NumRows = 31;

  // Directed rows: reset behavior, boot syncs at both ends of the span, the
  // reversed and downward spans, saturation, zero settle and a full deadband.
  localparam dir_row_t DirRows [NumRows] = '{
    '{ROW_ITEM, CFG_SPAN_LOW,  16'h0000, 12'd4095, 1'b0, CHK_PRED,  9'sd0,    1'b0},
    '{ROW_ITEM, CFG_SPAN_LOW,  16'h0000, 12'd0,    1'b0, CHK_PRED,  9'sd0,    1'b0},
    '{ROW_ITEM, CFG_SPAN_LOW,  16'h0000, 12'd0,    1'b1, CHK_NONE,  9'sd0,    1'b0},
    '{ROW_CFG,  CfgIdxSpare,   16'hFFFF, 12'd0,    1'b0, CHK_NONE,  9'sd0,    1'b0},
    '{ROW_CFG,  CFG_SPAN_LOW,  16'h8000, 12'd0,    1'b0, CHK_NONE,  9'sd0,    1'b0},
    '{ROW_CFG,  CFG_SPAN_HIGH, 16'h0000, 12'd0,    1'b0, CHK_NONE,  9'sd0,    1'b0},
    '{ROW_CFG,  CFG_DEADBAND,  16'h0000, 12'd0,    1'b0, CHK_NONE,  9'sd0,    1'b0},
    '{ROW_CFG,  CFG_SETTLE,    16'h0001, 12'd0,    1'b0, CHK_NONE,  9'sd0,    1'b0},
    '{ROW_ITEM, CFG_SPAN_LOW,  16'h0000, 12'd4095, 1'b1, CHK_NONE,  9'sd0,    1'b0},
    '{ROW_ITEM, CFG_SPAN_LOW,  16'h0000, 12'd4095, 1'b0, CHK_LEVEL, 9'sd0,    1'b1},
    '{ROW_ITEM, CFG_SPAN_LOW,  16'h0000, 12'd0,    1'b1, CHK_NONE,  9'sd0,    1'b0},
    '{ROW_ITEM, CFG_SPAN_LOW,  16'h0000, 12'd0,    1'b0, CHK_LEVEL, -9'sd256, 1'b1},
    '{ROW_ITEM, CFG_SPAN_LOW,  16'h0000, 12'd4095, 1'b0, CHK_PRED,  9'sd0,    1'b0},
    '{ROW_ITEM, CFG_SPAN_LOW,  16'h0000, 12'd4095, 1'b0, CHK_PRED,  9'sd0,    1'b0},
    '{ROW_ITEM, CFG_SPAN_LOW,  16'h0000, 12'd2048, 1'b0, CHK_PRED,  9'sd0,    1'b0},
    '{ROW_CFG,  CFG_REVERSE,   16'h0001, 12'd0,    1'b0, CHK_NONE,  9'sd0,    1'b0},
    '{ROW_ITEM, CFG_SPAN_LOW,  16'h0000, 12'd0,    1'b0, CHK_PRED,  9'sd0,    1'b0},
    '{ROW_ITEM, CFG_SPAN_LOW,  16'h0000, 12'd4095, 1'b0, CHK_PRED,  9'sd0,    1'b0},
    '{ROW_CFG,  CFG_SPAN_LOW,  16'h0000, 12'd0,    1'b0, CHK_NONE,  9'sd0,    1'b0},
    '{ROW_CFG,  CFG_SPAN_HIGH, 16'h8000, 12'd0,    1'b0, CHK_NONE,  9'sd0,    1'b0},
    '{ROW_CFG,  CFG_REVERSE,   16'h0000, 12'd0,    1'b0, CHK_NONE,  9'sd0,    1'b0},
    '{ROW_ITEM, CFG_SPAN_LOW,  16'h0000, 12'd4095, 1'b0, CHK_PRED,  9'sd0,    1'b0},
    '{ROW_ITEM, CFG_SPAN_LOW,  16'h0000, 12'd0,    1'b0, CHK_PRED,  9'sd0,    1'b0},
    '{ROW_CFG,  CFG_SPAN_HIGH, 16'h7FFF, 12'd0,    1'b0, CHK_NONE,  9'sd0,    1'b0},
    '{ROW_CFG,  CFG_SETTLE,    16'h0000, 12'd0,    1'b0, CHK_NONE,  9'sd0,    1'b0},
    '{ROW_CFG,  CFG_DEADBAND,  16'h0FFF, 12'd0,    1'b0, CHK_NONE,  9'sd0,    1'b0},
    '{ROW_ITEM, CFG_SPAN_LOW,  16'h0000, 12'd4095, 1'b1, CHK_NONE,  9'sd0,    1'b0},
    '{ROW_ITEM, CFG_SPAN_LOW,  16'h0000, 12'd4095, 1'b0, CHK_NONE,  9'sd0,    1'b0},
    '{ROW_CFG,  CFG_DEADBAND,  16'h0000, 12'd0,    1'b0, CHK_NONE,  9'sd0,    1'b0},
    '{ROW_ITEM, CFG_SPAN_LOW,  16'h0000, 12'd4095, 1'b0, CHK_PRED,  9'sd0,    1'b0},
    '{ROW_ITEM, CFG_SPAN_LOW,  16'h0000, 12'd0,    1'b0, CHK_PRED,  9'sd0,    1'b0}
  };

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [CfgIdxW-1:0] cfg_addr_i;
  logic [SpanW-1:0]   cfg_wdata_i;
  logic               s_axis_tvalid;
  logic               s_axis_tready;
  logic [15:0]        s_axis_tdata;   // [11:0] sample
  logic               s_axis_tuser;   // [0] start_req
  logic               m_axis_tvalid;
  logic               m_axis_tready;
  logic [15:0]        m_axis_tdata;   // [8:0] level_half_db
  logic               m_axis_tuser;   // [0] boot_sync

  pot_ema_deadband_quantizer uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  // Shadow copy of the configuration registers.
  logic signed [SpanW-1:0] span_lo_r   = SpanLowRst;
  logic signed [SpanW-1:0] span_hi_r   = SpanHighRst;
  logic                    reverse_r   = 1'b0;
  logic [SampleW-1:0]      deadband_r  = DeadbandRst;
  logic [SettleW-1:0]      settle_r    = SettleRst;

  // Shadow copy of the filter and send state.
  logic [SampleW-1:0]       ema_filt     = '0;
  logic [SettleW-1:0]       settle_cnt   = '0;
  logic [SampleW-1:0]       sent_raw_q   = '0;
  logic signed [LevelW-1:0] sent_level_q = '0;

  level_t due_levels[$];

  int  err_cnt       = 0;
  int  items_sent    = 0;
  int  levels_seen   = 0;
  int  boots_seen    = 0;
  int  cycle_cnt     = 0;
  int  hold_left     = 0;
  bit  hold_off_req  = 1'b0;
  bit  calm          = 1'b0;
  int  pot_pos       = 2048;

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Maps a filtered value onto the span in half-dB units, rounding half away
  // from zero and saturating to the level width.
  function automatic logic signed [LevelW-1:0] map_half_db(logic [SampleW-1:0] f);
    longint p, num, q;
    p = reverse_r ? (longint'(FullScale) - longint'(f)) : longint'(f);
    num = longint'(span_lo_r) * longint'(FullScale)
        + (longint'(span_hi_r) - longint'(span_lo_r)) * p;
    if (num >= 0) begin
      q = (num + MapDenom / 2) / MapDenom;
    end else begin
      q = -((-num + MapDenom / 2) / MapDenom);
    end
    if (q > 255) q = 255;
    if (q < -256) q = -256;
    return LevelW'(q);
  endfunction

  // Advances the filter by one sample and returns the level it sends, if any.
  function automatic step_out_t ema_step(logic [SampleW-1:0] smp, logic st);
    step_out_t res;
    int diff, moved;
    logic signed [LevelW-1:0] lvl;
    res = '0;
    if (st) begin
      ema_filt   = smp;
      settle_cnt = settle_r;
      return res;
    end
    diff = int'(smp) - int'(ema_filt);
    ema_filt = SampleW'(int'(ema_filt) + diff / EmaDiv);
    if (settle_cnt != 0) begin
      settle_cnt = settle_cnt - 10'd1;
      if (settle_cnt != 0) return res;
      sent_level_q = map_half_db(ema_filt);
      sent_raw_q   = ema_filt;
      res.valid     = 1'b1;
      res.lvl.level = sent_level_q;
      res.lvl.boot  = 1'b1;
      return res;
    end
    moved = int'(ema_filt) - int'(sent_raw_q);
    if (moved < 0) moved = -moved;
    if (moved <= int'(deadband_r)) return res;
    lvl = map_half_db(ema_filt);
    if (lvl == sent_level_q) return res;
    sent_level_q  = lvl;
    sent_raw_q    = ema_filt;
    res.valid     = 1'b1;
    res.lvl.level = lvl;
    res.lvl.boot  = 1'b0;
    return res;
  endfunction

  // Register writes to unknown indexes leave the shadow untouched.
  function automatic void apply_reg(logic [CfgIdxW-1:0] idx, logic [SpanW-1:0] v);
    case (idx)
      CFG_SPAN_LOW:  span_lo_r  = v;
      CFG_SPAN_HIGH: span_hi_r  = v;
      CFG_REVERSE:   reverse_r  = v[0];
      CFG_DEADBAND:  deadband_r = v[SampleW-1:0];
      CFG_SETTLE:    settle_r   = v[SettleW-1:0];
      default: ;
    endcase
  endfunction

  function automatic logic [SampleW-1:0] clamp_sample(int v);
    if (v < 0) return '0;
    if (v > int'(FullScale)) return FullScale;
    return SampleW'(v);
  endfunction

  function automatic logic [SpanW-1:0] rand_span();
    if ($urandom_range(99) < 80) return SpanW'(-int'($urandom_range(32768)));
    return SpanW'($urandom);
  endfunction

  // Picks one of the register indexes past the last defined register.
  function automatic logic [CfgIdxW-1:0] pick_spare_idx();
    return CfgIdxW'($urandom_range(2 ** CfgIdxW - 1, int'(CfgIdxSpare)));
  endfunction

  // Waits until the block is idle, then writes one register.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [SpanW-1:0] v);
    s_axis_tvalid <= 1'b0;
    while (due_levels.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= v;
    apply_reg(idx, v);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Offers one sample item and records what it should produce.
  task automatic send_sample(input logic [SampleW-1:0] smp, input logic st,
                             input row_chk_e chk, input level_t typed_lvl);
    step_out_t res;
    while (!calm && $urandom_range(99) < IdlePct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0, smp};
    s_axis_tuser  <= st;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    items_sent++;
    res = ema_step(smp, st);
    case (chk)
      CHK_PRED:  if (res.valid) due_levels.push_back(res.lvl);
      CHK_LEVEL: due_levels.push_back(typed_lvl);
      default: ;
    endcase
  endtask

  // Receiver: random stalls, one long hold-off on request, none when calm.
  initial begin
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold_left    = HoldCycles;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= calm || ($urandom_range(99) >= IdlePct);
      end
    end
  end

  // Compare each level item against the oldest pending expectation.
  always @(posedge clk_i) begin : level_check
    level_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      levels_seen++;
      if (m_axis_tuser) boots_seen++;
      if (due_levels.size() == 0) begin
        err_cnt++;
        $display("%0t: unexpected level item: expected none, actual %0d boot %0b",
                 $time, $signed(m_axis_tdata[LevelW-1:0]), m_axis_tuser);
      end else begin
        want = due_levels.pop_front();
        if (m_axis_tdata[LevelW-1:0] !== want.level) begin
          err_cnt++;
          $display("%0t: level mismatch: expected %0d, actual %0d", $time,
                   want.level, $signed(m_axis_tdata[LevelW-1:0]));
        end
        if (m_axis_tuser !== want.boot) begin
          err_cnt++;
          $display("%0t: boot_sync mismatch: expected %0b, actual %0b", $time,
                   want.boot, m_axis_tuser);
        end
      end
    end
  end

  // Watchdog.
  initial begin
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("%0t: run did not finish within %0d cycles", $time, CycleLimit);
    $display("simulation failed");
    $finish;
  end

  // Main sequence: reset, directed rows, then randomized phases.
  initial begin
    logic [SpanW-1:0]    lo, hi;
    logic                rev;
    logic [SampleW-1:0]  db, smp;
    logic [SettleW-1:0]  stl;
    logic                st;
    int                  n_items, start_pct;

    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_addr_i    <= CFG_SPAN_LOW;
    cfg_wdata_i   <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DirRows[r]) begin
      if (DirRows[r].kind == ROW_CFG) begin
        write_reg(DirRows[r].idx, DirRows[r].value);
      end else begin
        send_sample(DirRows[r].smp, DirRows[r].st, DirRows[r].chk,
                    '{DirRows[r].exp_level, DirRows[r].exp_boot});
      end
    end

    for (int ph = 0; ph < NumPhases; ph++) begin
      n_items   = 75;
      start_pct = 1;
      case (ph)
        0: begin
          lo = 16'h8000; hi = 16'h0000; rev = 1'b0; db = 12'd0; stl = 10'd1;
          n_items = 120;
        end
        1: begin
          lo = 16'h0000; hi = 16'h8000; rev = 1'b1; db = 12'd4095; stl = 10'd2;
          start_pct = 4;
        end
        2: begin
          lo = 16'h0000; hi = 16'h7FFF; rev = 1'b0; db = 12'd1; stl = 10'd0;
        end
        LongPhase: begin
          lo = SpanLowRst; hi = SpanHighRst; rev = 1'b0; db = 12'd12; stl = 10'd1023;
          n_items = 1040;
          start_pct = 0;
        end
        default: begin
          lo  = rand_span();
          hi  = rand_span();
          rev = 1'($urandom);
          db  = ($urandom_range(99) < 70) ? 12'($urandom_range(40)) : 12'($urandom);
          case ($urandom_range(5))
            0:       stl = '0;
            1:       stl = 10'($urandom_range(1023));
            default: stl = 10'($urandom_range(30, 1));
          endcase
        end
      endcase
      calm = 1'b0;
      write_reg(CFG_SPAN_LOW, lo);
      write_reg(CFG_SPAN_HIGH, hi);
      write_reg(CFG_REVERSE, {15'b0, rev});
      write_reg(CFG_DEADBAND, {4'b0, db});
      write_reg(CFG_SETTLE, {6'b0, stl});
      if ($urandom_range(2) == 0) begin
        write_reg(pick_spare_idx(), SpanW'($urandom));
      end
      calm = (ph == CalmPhase);
      if (ph == 0) hold_off_req = 1'b1;

      // A pot that mostly drifts, sometimes jumps, with some noise samples.
      for (int k = 0; k < n_items; k++) begin
        if ($urandom_range(99) < 3) begin
          pot_pos = $urandom_range(4095);
        end else begin
          pot_pos = int'(clamp_sample(pot_pos + int'($urandom_range(80)) - 40));
        end
        if ($urandom_range(99) < 8) begin
          smp = SampleW'($urandom);
        end else begin
          smp = clamp_sample(pot_pos + int'($urandom_range(6)) - 3);
        end
        st = (k == 0) || (int'($urandom_range(99)) < start_pct);
        send_sample(smp, st, CHK_PRED, '0);
      end
    end

    s_axis_tvalid <= 1'b0;
    while (due_levels.size() != 0) @(posedge clk_i);
    repeat (2 * DrainCycles) @(posedge clk_i);
    if (due_levels.size() != 0) begin
      err_cnt++;
      $display("%0t: expected %0d more level items, actual none", $time,
               due_levels.size());
    end

    $display("Covered %0d sample items over %0d config phases plus directed rows,",
             items_sent, NumPhases);
    $display("and checked %0d level items, %0d of them boot syncs.",
             levels_seen, boots_seen);
    if (err_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
